@@ src/mfr_pkg.sv @@
// Shared constants, register map and CRC-16 byte step for the Modbus frame receiver.
package mfr_pkg;

  localparam int MAX_PARAMS_DEF = 32;
  localparam int PC_W           = 6;   // width of the parameter count field

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ADDR  = 2'd1;
  localparam logic [1:0] STAT_CRC   = 2'd2;
  localparam logic [1:0] STAT_SHORT = 2'd3;

  // configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] REG_TEST_CODE = 2'd1;
  localparam logic [1:0] REG_SET_CMD   = 2'd2;

  // reset values
  localparam logic [7:0] DEV_ADDR_RST  = 8'd1;
  localparam logic [7:0] TEST_CODE_RST = 8'd3;
  localparam logic [7:0] SET_CMD_RST   = 8'd16;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_TAP_MASK = 16'hA001;

  // minimum frame lengths
  localparam logic [7:0] MIN_LEN_ANY  = 8'd4;
  localparam logic [7:0] MIN_LEN_TEST = 8'd5;
  localparam logic [7:0] MIN_LEN_SET  = 8'd8;

  localparam logic [7:0] POS_MAX = 8'hFF;

  // one byte through reflected CRC-16/MODBUS
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_TAP_MASK;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

@@ src/modbus_frame_receiver_core.sv @@
// Modbus RTU frame receiver: CRC check, header decode and parameter byte replay.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  s_*     | in        | s_tvalid / s_tready    | s_tdata: rx_byte; s_tlast: frame_end
//  m_*     | out       | m_tvalid / m_tready    | m_tdata, m_tuser: is_param, m_tlast: last
//  apb     | in        | psel/penable/pwrite    | 3 byte registers at 0x0, 0x4, 0x8
//
// Bytes inside a frame are taken one per cycle. On the frame's final byte the
// input stalls: the EVAL state evaluates the header, the header result is shown,
// then each parameter byte is read from the parameter buffer memory (registered
// read, in a LOAD state) and shown. The input opens again the cycle after the last
// result is taken. Synchronous reset clears control state and the frame registers.
module modbus_frame_receiver_core
  import mfr_pkg::*;
#(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // frame_end
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [1:0] status, [9:2] command, [25:10] mem_addr,
                                 // [41:26] memory_count, [47:42] param_count,
                                 // [55:48] param_byte
  output logic        m_tuser,   // is_param
  output logic        m_tlast,   // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int         AW    = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [7:0] MAX_B = 8'(MAX_PARAMS);

  localparam logic [2:0] S_RX   = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_PRM  = 3'd4;

  logic [2:0] state, state_next;

  // configuration registers
  logic [7:0] dev_addr, test_code, set_cmd;
  logic       cfg_wr;

  // frame state
  logic [15:0] crc;
  logic [7:0]  pos;
  logic [7:0]  hdr0, hdr1, hdr2, hdr3, hdr4, hdr5;
  logic [15:0] last_two;

  // parameter buffer
  logic [7:0]    pbuf [MAX_PARAMS];
  logic [7:0]    rd_q;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [7:0]    pos_off;
  logic [PC_W-1:0] idx;
  logic [PC_W-1:0] idx_inc;

  // output registers
  logic            out_valid;
  logic            out_isp;
  logic [1:0]      out_status;
  logic [7:0]      out_cmd;
  logic [15:0]     out_maddr;
  logic [15:0]     out_mcount;
  logic [PC_W-1:0] out_pc;
  logic [7:0]      out_pbyte;
  logic            out_last;

  logic in_acc, out_acc;

  // header evaluation
  logic        is_test, is_set;
  logic [7:0]  min_len;
  logic [15:0] want;
  logic [1:0]  status_c;
  logic [7:0]  room, cap1, cap2;
  logic [PC_W-1:0] pc_c;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr  <= DEV_ADDR_RST;
      test_code <= TEST_CODE_RST;
      set_cmd   <= SET_CMD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DEV_ADDR:  dev_addr  <= pwdata[7:0];
        REG_TEST_CODE: test_code <= pwdata[7:0];
        REG_SET_CMD:   set_cmd   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DEV_ADDR:  prdata = {24'h0, dev_addr};
      REG_TEST_CODE: prdata = {24'h0, test_code};
      REG_SET_CMD:   prdata = {24'h0, set_cmd};
      default:       prdata = 32'h0;
    endcase
  end

  // ---------------- handshakes ----------------
  assign s_tready = (state == S_RX);
  assign in_acc   = s_tvalid && s_tready;
  assign out_acc  = out_valid && m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_isp;
  assign m_tlast  = out_last;
  assign m_tdata  = {out_pbyte, out_pc, out_mcount, out_maddr, out_cmd, out_status};

  // ---------------- parameter buffer memory ----------------
  assign pos_off = pos - 8'd3;
  assign wr_en   = in_acc && (pos >= 8'd3) && (pos_off < MAX_B);
  assign wr_addr = pos_off[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) pbuf[wr_addr] <= s_tdata;
    rd_q <= pbuf[idx[AW-1:0]];
  end

  // ---------------- header evaluation ----------------
  always_comb begin
    is_test = (hdr1 == test_code);
    is_set  = !is_test && (hdr1 == set_cmd);
    min_len = is_test ? MIN_LEN_TEST : (is_set ? MIN_LEN_SET : MIN_LEN_ANY);
    want    = {crc[7:0], crc[15:8]};
    if (pos < min_len)          status_c = STAT_SHORT;
    else if (hdr0 != dev_addr)  status_c = STAT_ADDR;
    else if (last_two != want)  status_c = STAT_CRC;
    else                        status_c = STAT_OK;
    room = pos - MIN_LEN_TEST;
    cap1 = (hdr2 > room) ? room : hdr2;
    cap2 = (cap1 > MAX_B) ? MAX_B : cap1;
    pc_c = (status_c == STAT_OK && is_test) ? cap2[PC_W-1:0] : '0;
  end

  assign idx_inc = idx + PC_W'(1);

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_RX:   if (in_acc && s_tlast) state_next = S_EVAL;
      S_EVAL: state_next = S_HDR;
      S_HDR:  if (out_acc) state_next = out_last ? S_RX : S_LOAD;
      S_LOAD: state_next = S_PRM;
      S_PRM:  if (out_acc) state_next = out_last ? S_RX : S_LOAD;
      default: state_next = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_RX;
    else     state <= state_next;
  end

  // frame registers: updated per byte, cleared once the header is evaluated
  always_ff @(posedge clk) begin
    if (rst || state == S_EVAL) begin
      crc      <= CRC_INIT;
      pos      <= '0;
      hdr0     <= '0;
      hdr1     <= '0;
      hdr2     <= '0;
      hdr3     <= '0;
      hdr4     <= '0;
      hdr5     <= '0;
      last_two <= '0;
    end else if (in_acc) begin
      // CRC lags two bytes so the check bytes stay out of it
      if (pos >= 8'd2) crc <= crc16_byte(crc, last_two[15:8]);
      last_two <= {last_two[7:0], s_tdata};
      case (pos)
        8'd0: hdr0 <= s_tdata;
        8'd1: hdr1 <= s_tdata;
        8'd2: hdr2 <= s_tdata;
        8'd3: hdr3 <= s_tdata;
        8'd4: hdr4 <= s_tdata;
        8'd5: hdr5 <= s_tdata;
        default: ;
      endcase
      if (pos != POS_MAX) pos <= pos + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      unique case (state)
        S_EVAL: begin
          out_valid <= 1'b1;
          idx       <= '0;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          idx       <= idx_inc;
        end
        default: if (out_acc) out_valid <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      out_isp    <= 1'b0;
      out_status <= status_c;
      out_cmd    <= hdr1;
      out_maddr  <= (status_c == STAT_OK && is_set) ? {hdr2, hdr3} : 16'h0;
      out_mcount <= (status_c == STAT_OK && is_set) ? {hdr4, hdr5} : 16'h0;
      out_pc     <= pc_c;
      out_pbyte  <= '0;
      out_last   <= (pc_c == '0);
    end else if (state == S_LOAD) begin
      // command and count carry over from the header result
      out_isp    <= 1'b1;
      out_status <= STAT_OK;
      out_maddr  <= 16'h0;
      out_mcount <= 16'h0;
      out_pbyte  <= rd_q;
      out_last   <= (idx_inc == out_pc);
    end
  end

`ifndef SYNTHESIS
  // no new byte is taken while a result is pending
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  // parameter results only follow a nonzero, capped count
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_pc != '0 && 8'(out_pc) <= MAX_B))
    else $error("parameter result with bad count");

  // a failed frame ends with its header
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser && out_status != STAT_OK) |-> m_tlast)
    else $error("failed frame header not marked last");

  // the input reopens right after the final result of a frame
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("input not reopened after frame results");
`endif

endmodule
